[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, reset-qualified on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the RSA block decrypt unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int CIPHER_W  = 32;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_ACC,
    OP_SQUARE
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    mul_op_e op;
    logic    mul_step;
    logic    wb_acc;
    logic    wb_base;
    logic    exp_shift;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_bit;
    logic mod_zero;
  } dp_status_t;

endpackage

[sv/rbd_datapath.sv]
// ----------------------------------------------------------------------------
// rbd_datapath
// Key registers, accumulator, base and a one-bit-per-cycle modular multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbd_datapath import rbd_pkg::*; #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [MOD_WIDTH-1:0]  cfg_wdata_i,
  input  logic [CIPHER_W-1:0]   cipher_i,
  input  logic                  last_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic [CHAR_W-1:0]     high_char_o,
  output logic [CHAR_W-1:0]     low_char_o,
  output logic                  last_o
);

  localparam int W = MOD_WIDTH;

  logic [W-1:0]   mod_q, exp_q;
  logic [W-1:0]   c_q, acc_q, base_q, e_q;
  logic [W-1:0]   a_q, b_q, r_q, r_d;
  logic           last_q;
  logic [CHAR_W-1:0] high_q, low_q;
  logic           out_last_q;
  logic [W-1:0]   one_w;
  logic [W+1:0]   sum_w, n1_w, n2_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= W'(1);
      exp_q <= W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODULUS:  mod_q <= cfg_wdata_i;
        REG_EXPONENT: exp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign one_w = (mod_q > W'(1)) ? W'(1) : '0;

  // r = (2r + bit*a) mod n, with 2r + a below 3n
  always_comb begin
    n1_w  = {2'b00, mod_q};
    n2_w  = {1'b0, mod_q, 1'b0};
    sum_w = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
    if (sum_w >= n2_w) begin
      r_d = W'(sum_w - n2_w);
    end else if (sum_w >= n1_w) begin
      r_d = W'(sum_w - n1_w);
    end else begin
      r_d = W'(sum_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q    <= W'(cipher_i);
      last_q <= last_i;
      acc_q  <= one_w;
      e_q    <= exp_q;
    end
    if (cmd_i.mul_start) begin
      r_q <= '0;
      case (cmd_i.op)
        OP_REDUCE: begin
          a_q <= one_w;
          b_q <= c_q;
        end
        OP_ACC: begin
          a_q <= acc_q;
          b_q <= base_q;
        end
        OP_SQUARE: begin
          a_q <= base_q;
          b_q <= base_q;
        end
        default: begin
          a_q <= '0;
          b_q <= '0;
        end
      endcase
    end else if (cmd_i.mul_step) begin
      r_q <= r_d;
      b_q <= {b_q[W-2:0], 1'b0};
    end
    if (cmd_i.wb_acc) begin
      acc_q <= r_q;
    end
    if (cmd_i.wb_base) begin
      base_q <= r_q;
    end
    if (cmd_i.exp_shift) begin
      e_q <= {1'b0, e_q[W-1:1]};
    end
    if (cmd_i.out_load) begin
      high_q     <= acc_q[2*CHAR_W-1:CHAR_W];
      low_q      <= acc_q[CHAR_W-1:0];
      out_last_q <= last_q;
    end
  end

  assign status_o.exp_bit  = e_q[0];
  assign status_o.mod_zero = (mod_q == '0);
  assign high_char_o       = high_q;
  assign low_char_o        = low_q;
  assign last_o            = out_last_q;

endmodule

[sv/rbd_ctrl.sv]
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer for reduction, square-and-multiply and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbd_ctrl import rbd_pkg::*; #(
  parameter int MOD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int CW = $clog2(MOD_WIDTH);
  localparam logic [CW-1:0] LAST = CW'(MOD_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_WB,
    ST_BIT,
    ST_FINISH
  } state_e;

  state_e          state_q, state_d;
  mul_op_e         op_q, op_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = op_q;
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~m_ready_i;
    s_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (status_i.mod_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.op        = OP_REDUCE;
          op_d            = OP_REDUCE;
          cnt_d           = LAST;
          idx_d           = '0;
          state_d         = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        case (op_q)
          OP_REDUCE: begin
            cmd_o.wb_base = 1'b1;
            state_d       = ST_BIT;
          end
          OP_ACC: begin
            cmd_o.wb_acc = 1'b1;
            if (idx_q == LAST) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.mul_start = 1'b1;
              cmd_o.op        = OP_SQUARE;
              op_d            = OP_SQUARE;
              cnt_d           = LAST;
              state_d         = ST_MUL;
            end
          end
          OP_SQUARE: begin
            cmd_o.wb_base   = 1'b1;
            cmd_o.exp_shift = 1'b1;
            idx_d           = idx_q + CW'(1);
            state_d         = ST_BIT;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_BIT: begin
        if (status_i.exp_bit) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.op        = OP_ACC;
          op_d            = OP_ACC;
          cnt_d           = LAST;
          state_d         = ST_MUL;
        end else if (idx_q == LAST) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.op        = OP_SQUARE;
          op_d            = OP_SQUARE;
          cnt_d           = LAST;
          state_d         = ST_MUL;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_REDUCE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

[sv/rsa_block_decrypt_unit.sv]
// Sequence: a zero modulus goes straight to the result handoff; otherwise the block is first reduced
//   mod n, then each exponent bit, from the lowest, takes a multiply if set and a square unless it
//   is the last bit.
// Throughput: one item at a time; the next item is accepted in the cycle after the result loads,
//   and a stalled result holds the handoff. Reset: modulus and exponent return to 1, the
//   sequencer idles and the output is empty.
// ----------------------------------------------------------------------------
// rsa_block_decrypt_unit
// RSA block decryption m = c^d mod n by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsa_block_decrypt_unit import rbd_pkg::*; #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [MOD_WIDTH-1:0]  cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [31:0] cipher_block
  input  logic                  s_axis_tlast,   // last_block
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [7:0] high_char, [15:8] low_char
  output logic                  m_axis_tlast    // last_out
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rbd_ctrl #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rbd_datapath #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cipher_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .high_char_o (m_axis_tdata[7:0]),
    .low_char_o  (m_axis_tdata[15:8]),
    .last_o      (m_axis_tlast)
  );

endmodule

[sv/rbd_checker.sv]
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks of the RSA block decrypt unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  `ASSERT_NEXT(a_no_result_after_accept, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "early result")
  `ASSERT_SAME(a_idle_on_result, $rose(m_axis_tvalid), s_axis_tready, "not idle when result shows")
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled item changed")

endmodule

bind rsa_block_decrypt_unit rbd_checker u_rbd_checker (.*);

[tb/rsa_decrypt_checker.sv]
// ----------------------------------------------------------------------------
// rsa_decrypt_checker
// Watches the key write port and both stream channels of the RSA block
// decrypt unit. Each accepted cipher block is turned into its expected
// character pair (c^d mod n, bits 15..0) under the key in force. Each
// accepted output item is compared field by field against the oldest pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsa_decrypt_checker import rbd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [31:0]          s_data_i,
  input  logic                 s_last_i,
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [15:0]          m_data_i,
  input  logic                 m_last_i,
  output int                   err_cnt_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] high_char;
    logic [CHAR_W-1:0] low_char;
    logic              last_out;
  } char_pair_t;

  logic [31:0] key_modulus;
  logic [31:0] key_exponent;
  char_pair_t  plain_q[$];
  int          mismatches;
  int          checked;

  function automatic logic [31:0] modexp_plaintext(input logic [31:0] cipher,
                                                   input logic [31:0] n,
                                                   input logic [31:0] d);
    logic [63:0] acc;
    logic [63:0] base;
    if (n == 32'd0) return 32'd0;
    acc  = 64'd1 % {32'd0, n};
    base = {32'd0, cipher} % {32'd0, n};
    for (int i = 0; i < 32; i++) begin
      if (d[i]) acc = (acc * base) % {32'd0, n};
      base = (base * base) % {32'd0, n};
    end
    return acc[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_pair_t  want;
    char_pair_t  got;
    logic [31:0] plain;
    if (!rst_ni) begin
      key_modulus  = 32'd1;
      key_exponent = 32'd1;
      mismatches   = 0;
      checked      = 0;
      plain_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODULUS:  key_modulus  = cfg_wdata_i;
          REG_EXPONENT: key_exponent = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        plain          = modexp_plaintext(s_data_i, key_modulus, key_exponent);
        want.high_char = plain[15:8];
        want.low_char  = plain[7:0];
        want.last_out  = s_last_i;
        plain_q.push_back(want);
      end
      if (m_valid_i && m_ready_i) begin
        got.high_char = m_data_i[7:0];
        got.low_char  = m_data_i[15:8];
        got.last_out  = m_last_i;
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got high=%02h low=%02h last=%0b",
                   $time, got.high_char, got.low_char, got.last_out);
          mismatches++;
        end else begin
          want = plain_q.pop_front();
          checked++;
          if (got.high_char !== want.high_char) begin
            $display("%0t: high_char expected %02h got %02h",
                     $time, want.high_char, got.high_char);
            mismatches++;
          end
          if (got.low_char !== want.low_char) begin
            $display("%0t: low_char expected %02h got %02h",
                     $time, want.low_char, got.low_char);
            mismatches++;
          end
          if (got.last_out !== want.last_out) begin
            $display("%0t: last_out expected %0b got %0b",
                     $time, want.last_out, got.last_out);
            mismatches++;
          end
        end
      end
    end
    err_cnt_o <= mismatches;
    pending_o <= plain_q.size();
    checked_o <= checked;
  end

endmodule

[tb/tb_rsa_block_decrypt_unit.sv]
// ----------------------------------------------------------------------------
// tb_rsa_block_decrypt_unit
// Drives cipher blocks into the RSA block decrypt unit under a series of
// keys, from degenerate moduli and exponents to full 32-bit values, with
// random gaps and output stalls, and a long output hold that backs up the
// input. A separate checker predicts and compares every output item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rsa_block_decrypt_unit;
  import rbd_pkg::*;

  localparam int                   MOD_W          = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B    = 2'd3;
  localparam int                   TARGET_BLOCKS  = 290;
  localparam int                   RX_HOLD_CYCLES = 6000;
  localparam int                   DRAIN_CYCLES   = 2500;
  localparam longint               CYCLE_LIMIT    = 4000000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [MOD_W-1:0]     cfg_wdata;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [15:0]          m_tdata;
  logic                 m_tlast;

  int err_cnt;
  int pending;
  int checked;
  int hold_req;
  int hold_served;
  logic rx_steady;
  int blocks_sent;
  int keys_loaded;

  rsa_block_decrypt_unit #(
    .MOD_WIDTH(MOD_W)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast)
  );

  rsa_decrypt_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .s_valid_i  (s_tvalid),
    .s_ready_i  (s_tready),
    .s_data_i   (s_tdata),
    .s_last_i   (s_tlast),
    .m_valid_i  (m_tvalid),
    .m_ready_i  (m_tready),
    .m_data_i   (m_tdata),
    .m_last_i   (m_tlast),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [31:0] pick_modulus();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 3);
    if (r < 3) return $urandom_range(4, 65535);
    if (r == 3) return 32'hFFFF_0000 | $urandom_range(0, 65535);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_exponent();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 3);
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 4) return $urandom_range(4, 1023);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_cipher(input logic [31:0] n);
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return n;
      3: return n - 32'd1;
      4, 5, 6: return (n != 32'd0) ? ($urandom % n) : $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_key(input logic [31:0] n, input logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MODULUS;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_idx   <= REG_EXPONENT;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_idx   <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we    <= 1'b0;
    keys_loaded++;
  endtask

  task automatic send_block(input logic [31:0] cipher, input logic last, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cipher;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    blocks_sent++;
  endtask

  // output side: random stalls, a long hold on request, steady when asked
  initial begin
    hold_served = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (rx_steady || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                            : $urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: cycle limit reached, %0d items outstanding", $time, pending);
    $display("tb_rsa_block_decrypt_unit: done, errors");
    $finish;
  end

  initial begin
    logic [31:0] n;
    logic [31:0] d;
    int          len;
    int          phase;
    blocks_sent = 0;
    keys_loaded = 0;
    phase       = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_MODULUS;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    hold_req  <= 0;
    rx_steady <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset key: unit modulus, every plaintext is zero
    send_block(32'd0, 1'b0, 0);
    send_block(32'hFFFF_FFFF, 1'b1, 1);
    wait_idle();
    // zero modulus
    program_key(32'd0, 32'h1234_5678);
    send_block(32'hDEAD_BEEF, 1'b0, 0);
    send_block(32'd5, 1'b1, 0);
    wait_idle();
    // all-ones modulus and exponent
    program_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'd0, 1'b0, 0);
    send_block(32'hFFFF_FFFF, 1'b0, 0);
    send_block(32'hFFFF_FFFE, 1'b0, 2);
    send_block(32'd2, 1'b1, 0);
    wait_idle();
    // zero exponent
    program_key(32'hFFFF_FFFB, 32'd0);
    send_block(32'd12345, 1'b0, 0);
    send_block(32'd0, 1'b1, 0);
    wait_idle();
    // plaintext wider than 16 bits
    program_key(32'd1000003, 32'd65537);
    send_block(32'd999999, 1'b0, 0);
    send_block(32'd123456789, 1'b0, 0);
    send_block(32'd1000003, 1'b1, 0);
    wait_idle();
    program_key(32'd2, 32'h8000_0000);
    send_block(32'd3, 1'b0, 0);
    send_block(32'd4, 1'b1, 0);
    wait_idle();
    program_key(32'd251, 32'd7);
    send_block(32'd250, 1'b0, 0);
    send_block(32'd1, 1'b1, 0);
    wait_idle();

    // long output hold while blocks keep coming
    program_key($urandom | 32'h8000_0000, $urandom_range(2, 15));
    hold_req <= hold_req + 1;
    for (int k = 0; k < 5; k++) begin
      send_block($urandom, k == 4, 0);
    end
    wait_idle();

    while (blocks_sent < TARGET_BLOCKS) begin
      n = pick_modulus();
      d = pick_exponent();
      program_key(n, d);
      if (phase == 3) rx_steady <= 1'b1;
      len = $urandom_range(10, 30);
      for (int k = 0; k < len; k++) begin
        send_block(pick_cipher(n), (k == len - 1) || ($urandom_range(0, 9) == 0),
                   (phase == 3) ? 0 : pick_gap());
      end
      wait_idle();
      rx_steady <= 1'b0;
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d cipher blocks under %0d keys, %0d character pairs checked",
             blocks_sent, keys_loaded, checked);
    $display("keys ranged over zero, unit and full-width moduli and exponents");
    if (err_cnt == 0 && pending == 0) begin
      $display("tb_rsa_block_decrypt_unit: done, clean");
    end else begin
      $display("tb_rsa_block_decrypt_unit: done, errors");
    end
    $finish;
  end

endmodule
